/* sv/ctfc_pkg.sv */
// Types, tables and per-stage functions for the clock-tree frequency calculator.
package ctfc_pkg;

	// Widths and pipeline shape
	localparam int FREQ_W = 26;
	localparam int WORD_W = 32;
	localparam int NS     = 11;   // pipeline stages ahead of the output register
	localparam int STG_MUL2 = 6;  // PLL2 multiply and predivider-one setup
	localparam int STG_SYS  = 11; // main PLL multiply and source select

	localparam logic [FREQ_W-1:0] FREQ_RESET = 26'd8000000;

	// Configuration register indexes
	localparam logic [1:0] REG_CRYSTAL  = 2'd0;
	localparam logic [1:0] REG_INTERNAL = 2'd1;

	// Clock source codes
	localparam logic [1:0] SRC_INTERNAL     = 2'd0;
	localparam logic [1:0] SRC_CRYSTAL      = 2'd1;
	localparam logic [1:0] SRC_PLL          = 2'd2;
	localparam logic [1:0] SRC_INTERNAL_ALT = 2'd3;

	// Doubled multiplier and prescaler shift tables
	localparam logic [5:0] PLL_X2 [16] = '{6'd36, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18,
		6'd20, 6'd22, 6'd24, 6'd26, 6'd28, 6'd13, 6'd30, 6'd32};
	localparam logic [5:0] PLL2_X2 [16] = '{6'd5, 6'd25, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18,
		6'd20, 6'd22, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd40};
	localparam logic [3:0] AHB_SHIFT [16] = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9};
	localparam logic [2:0] APB_SHIFT [8] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4};

	// Input beat, last field in the lowest bits
	typedef struct packed {
		logic       pad;
		logic [2:0] apb2_presc_index;
		logic [2:0] apb1_presc_index;
		logic [3:0] ahb_presc_index;
		logic       internal_undivided;
		logic [3:0] prediv2_field;
		logic [3:0] pll2_mult_index;
		logic       prediv1_from_pll2;
		logic [3:0] prediv1_field;
		logic       pll_from_prediv;
		logic [3:0] pll_mult_index;
		logic [1:0] clock_source;
	} in_beat_t;

	// Output beat, last field in the lowest bits
	typedef struct packed {
		logic [WORD_W-1:0] apb2_hz;
		logic [WORD_W-1:0] apb1_hz;
		logic [WORD_W-1:0] ahb_hz;
		logic [WORD_W-1:0] system_hz;
	} out_beat_t;

	// Payload carried down the pipeline
	typedef struct packed {
		logic [WORD_W-1:0] num;     // dividend shifting out, quotient shifting in
		logic [3:0]        rem;     // partial remainder
		logic [4:0]        dvs;     // current divisor, 1..16
		logic [4:0]        prediv1;
		logic [5:0]        pll_mul;
		logic [5:0]        pll2_mul;
		logic [1:0]        src;
		logic              from_prediv;
		logic              from_pll2;
		logic              undiv;
		logic [3:0]        ahb_sh;
		logic [2:0]        apb1_sh;
		logic [2:0]        apb2_sh;
	} pipe_t;

	// Set up a new beat: crystal divided by predivider two comes first
	function automatic pipe_t load_stage(in_beat_t b, logic [FREQ_W-1:0] crystal);
		pipe_t p;
		p.num         = {6'd0, crystal};
		p.rem         = '0;
		p.dvs         = {1'b0, b.prediv2_field} + 5'd1;
		p.prediv1     = {1'b0, b.prediv1_field} + 5'd1;
		p.pll_mul     = PLL_X2[b.pll_mult_index];
		p.pll2_mul    = PLL2_X2[b.pll2_mult_index];
		p.src         = b.clock_source;
		p.from_prediv = b.pll_from_prediv;
		p.from_pll2   = b.prediv1_from_pll2;
		p.undiv       = b.internal_undivided;
		p.ahb_sh      = AHB_SHIFT[b.ahb_presc_index];
		p.apb1_sh     = APB_SHIFT[b.apb1_presc_index];
		p.apb2_sh     = APB_SHIFT[b.apb2_presc_index];
		return p;
	endfunction

	// Eight restoring division steps, one quotient bit each
	function automatic pipe_t div_step8(pipe_t p);
		pipe_t      r;
		logic [4:0] part;
		r = p;
		for (int i = 0; i < 8; i++) begin
			part  = {r.rem, r.num[WORD_W-1]};
			r.num = {r.num[WORD_W-2:0], 1'b0};
			if (part >= r.dvs) begin
				part     = part - r.dvs;
				r.num[0] = 1'b1;
			end
			r.rem = part[3:0];
		end
		return r;
	endfunction

	// PLL2 output, then pick the dividend for predivider one
	function automatic pipe_t mul2_stage(pipe_t p, logic [FREQ_W-1:0] crystal);
		pipe_t             r;
		logic [WORD_W-1:0] prod;
		r    = p;
		prod = p.num * {26'd0, p.pll2_mul};
		r.num = p.from_pll2 ? {1'b0, prod[WORD_W-1:1]} : {6'd0, crystal};
		r.rem = '0;
		r.dvs = p.prediv1;
		return r;
	endfunction

	// Main PLL product and system clock select; result lands in num
	function automatic pipe_t sys_stage(pipe_t p, logic [FREQ_W-1:0] crystal,
		logic [FREQ_W-1:0] internal);
		pipe_t             r;
		logic [WORD_W-1:0] pll_in;
		logic [WORD_W-1:0] prod;
		r = p;
		if (p.from_prediv)
			pll_in = p.num;
		else if (p.undiv)
			pll_in = {6'd0, internal};
		else
			pll_in = {7'd0, internal[FREQ_W-1:1]};
		prod = pll_in * {26'd0, p.pll_mul};
		case (p.src)
			SRC_CRYSTAL: r.num = {6'd0, crystal};
			SRC_PLL:     r.num = {1'b0, prod[WORD_W-1:1]};
			SRC_INTERNAL, SRC_INTERNAL_ALT: r.num = {6'd0, internal};
			default:     r.num = {6'd0, internal};
		endcase
		return r;
	endfunction

endpackage

/* sv/clock_tree_frequency_calc.sv */
// Clock-tree frequency calculator: pipelined system, AHB, APB1 and APB2 frequency math.
//
//  channel | direction | handshake            | payload
//  s_*     | in        | s_tvalid / s_tready  | s_tdata, 32 bits of clock-tree settings
//  m_*     | out       | m_tvalid / m_tready  | m_tdata, four 32-bit frequencies
//  cfg_*   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (oscillator frequencies)
//
// One beat is taken every cycle while the output side keeps up. The pipeline holds two
// 32-step restoring dividers (predivider two, predivider one),
// each spread over four stages of eight steps, plus load, two multiply stages and the
// output register. Reset empties every stage; the oscillator registers return to 8 MHz.
// A stall backs up stage by stage; empty stages keep filling, so no beat is lost or repeated.
module clock_tree_frequency_calc (
	input  logic        clk,
	input  logic        arst_n,
	// clock_source[1:0], pll_mult_index[5:2], pll_from_prediv[6], prediv1_field[10:7],
	// prediv1_from_pll2[11], pll2_mult_index[15:12], prediv2_field[19:16],
	// internal_undivided[20], ahb_presc_index[24:21], apb1_presc_index[27:25],
	// apb2_presc_index[30:28], zero[31]
	input  logic [31:0]  s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// system_hz[31:0], ahb_hz[63:32], apb1_hz[95:64], apb2_hz[127:96]
	output logic [127:0] m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [25:0]  cfg_data
);
	import ctfc_pkg::*;

	logic [FREQ_W-1:0] crystal_q;
	logic [FREQ_W-1:0] internal_q;

	pipe_t pipe_s [1:NS];
	logic  vld_s  [1:NS];
	pipe_t nxt    [1:NS];
	logic  rdy    [1:NS];
	logic  rdy_out;

	logic      out_vld_q;
	out_beat_t out_q;

	in_beat_t in_beat;

	assign in_beat   = in_beat_t'(s_tdata);
	assign cfg_ready = 1'b1;

	// Oscillator frequency registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crystal_q  <= FREQ_RESET;
			internal_q <= FREQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CRYSTAL:  crystal_q  <= cfg_data;
				REG_INTERNAL: internal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ready chain: a stage loads when empty or when its beat moves on
	always_comb begin
		rdy_out = !out_vld_q || m_tready;
		rdy[NS] = !vld_s[NS] || rdy_out;
		for (int k = NS - 1; k >= 1; k--)
			rdy[k] = !vld_s[k] || rdy[k + 1];
	end

	assign s_tready = rdy[1];

	// Next payload for each stage
	always_comb begin
		nxt[1] = load_stage(in_beat, crystal_q);
		for (int k = 2; k <= NS; k++) begin
			if (k == STG_MUL2)
				nxt[k] = mul2_stage(pipe_s[k - 1], crystal_q);
			else if (k == STG_SYS)
				nxt[k] = sys_stage(pipe_s[k - 1], crystal_q, internal_q);
			else
				nxt[k] = div_step8(pipe_s[k - 1]);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++)
				vld_s[k] <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy[1])
				vld_s[1] <= s_tvalid;
			for (int k = 2; k <= NS; k++)
				if (rdy[k])
					vld_s[k] <= vld_s[k - 1];
			if (rdy_out)
				out_vld_q <= vld_s[NS];
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		for (int k = 1; k <= NS; k++)
			if (rdy[k])
				pipe_s[k] <= nxt[k];
		if (rdy_out) begin
			out_q.system_hz <= pipe_s[NS].num;
			out_q.ahb_hz    <= pipe_s[NS].num >> pipe_s[NS].ahb_sh;
			out_q.apb1_hz   <= (pipe_s[NS].num >> pipe_s[NS].ahb_sh) >> pipe_s[NS].apb1_sh;
			out_q.apb2_hz   <= (pipe_s[NS].num >> pipe_s[NS].ahb_sh) >> pipe_s[NS].apb2_sh;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// Bus clocks never exceed the clock they are divided from
	a_clock_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_q.ahb_hz <= out_q.system_hz) && (out_q.apb1_hz <= out_q.ahb_hz)
			&& (out_q.apb2_hz <= out_q.ahb_hz))
		else $error("bus clock above its parent clock");

	// Input stalls only when every stage holds a beat
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> out_vld_q && vld_s[1] && vld_s[5] && vld_s[NS])
		else $error("input stalled with a bubble in the pipeline");

	// First divider finished with a remainder below its divisor
	a_div2_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[STG_MUL2 - 1] |-> ({1'b0, pipe_s[STG_MUL2 - 1].rem} < pipe_s[STG_MUL2 - 1].dvs))
		else $error("predivider two remainder out of range");

	// Second divider finished with a remainder below its divisor
	a_div1_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[STG_SYS - 1] |-> ({1'b0, pipe_s[STG_SYS - 1].rem} < pipe_s[STG_SYS - 1].dvs))
		else $error("predivider one remainder out of range");

endmodule

/* bench/clock_tree_frequency_calc_tb.sv */
// Self-checking bench for the clock-tree frequency calculator stream block.
module clock_tree_frequency_calc_tb;
	import ctfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int NUM_PHASES     = 8;
	localparam int RAND_PER_PHASE = 230;
	localparam int SETTLE_CYCLES  = 16;

	// Register codes the block does not decode
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	// Doubled PLL multipliers and prescaler shifts
	localparam logic [5:0] MAIN_X2 [16] = '{6'd36, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16,
		6'd18, 6'd20, 6'd22, 6'd24, 6'd26, 6'd28, 6'd13, 6'd30, 6'd32};
	localparam logic [5:0] AUX_X2 [16] = '{6'd5, 6'd25, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16,
		6'd18, 6'd20, 6'd22, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd40};
	localparam logic [3:0] AHB_SH [16] = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9};
	localparam logic [2:0] APB_SH [8] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4};

	// Oscillator settings per phase; phase 6 draws its own
	localparam logic [25:0] XTAL_SET [NUM_PHASES] = '{26'd8000000, 26'd50000000, 26'd1,
		26'h3FFFFFF, 26'd0, 26'd25000000, 26'd12000000, 26'd16000000};
	localparam logic [25:0] IRC_SET [NUM_PHASES] = '{26'd8000000, 26'd50000000, 26'd1,
		26'h3FFFFFF, 26'd0, 26'd8000000, 26'd48000000, 26'd4000000};

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic [31:0]  s_tdata   = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [127:0] m_tdata;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [25:0]  cfg_data  = '0;

	// Bench copy of the oscillator registers
	logic [25:0] xtal_hz = 26'd8000000;
	logic [25:0] irc_hz  = 26'd8000000;

	out_beat_t freq_q [$];
	out_beat_t cur_want = '0;
	int        fail_cnt = 0;
	int        idle_cyc = 0;
	int        burst_left = 0;
	bit        no_gaps = 1'b0;
	logic [11:0] cyc = '0;
	string     field_name [4] = '{"system_hz", "ahb_hz", "apb1_hz", "apb2_hz"};

	in_beat_t  dir_beat [$];
	bit        dir_known [$];
	out_beat_t dir_want [$];

	clock_tree_frequency_calc dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Work out the four bus frequencies for one set of clock-tree settings
	function automatic out_beat_t freq_predict(in_beat_t b);
		out_beat_t   r;
		logic [31:0] xt;
		logic [31:0] ir;
		logic [31:0] src;
		logic [31:0] pll_in;
		logic [31:0] prod;
		logic [31:0] sys;
		logic [31:0] ahb;
		xt = {6'd0, xtal_hz};
		ir = {6'd0, irc_hz};
		if (b.pll_from_prediv) begin
			if (b.prediv1_from_pll2) begin
				prod = (xt / ({28'd0, b.prediv2_field} + 32'd1)) * {26'd0, AUX_X2[b.pll2_mult_index]};
				src  = prod / 32'd2;
			end else begin
				src = xt;
			end
			pll_in = src / ({28'd0, b.prediv1_field} + 32'd1);
		end else begin
			pll_in = b.internal_undivided ? ir : ir / 32'd2;
		end
		prod = pll_in * {26'd0, MAIN_X2[b.pll_mult_index]};
		case (b.clock_source)
			SRC_CRYSTAL: sys = xt;
			SRC_PLL:     sys = prod / 32'd2;
			default:     sys = ir;
		endcase
		ahb = sys >> AHB_SH[b.ahb_presc_index];
		r.system_hz = sys;
		r.ahb_hz    = ahb;
		r.apb1_hz   = ahb >> APB_SH[b.apb1_presc_index];
		r.apb2_hz   = ahb >> APB_SH[b.apb2_presc_index];
		return r;
	endfunction

	function automatic in_beat_t mk_beat(logic [1:0] src, logic [3:0] pllm, logic fp,
		logic [3:0] p1, logic fp2, logic [3:0] p2m, logic [3:0] p2, logic undiv,
		logic [3:0] ahb, logic [2:0] apb1, logic [2:0] apb2);
		in_beat_t b;
		b.pad                = 1'b0;
		b.clock_source       = src;
		b.pll_mult_index     = pllm;
		b.pll_from_prediv    = fp;
		b.prediv1_field      = p1;
		b.prediv1_from_pll2  = fp2;
		b.pll2_mult_index    = p2m;
		b.prediv2_field      = p2;
		b.internal_undivided = undiv;
		b.ahb_presc_index    = ahb;
		b.apb1_presc_index   = apb1;
		b.apb2_presc_index   = apb2;
		return b;
	endfunction

	// Random settings, with the PLL selected at least half the time
	function automatic in_beat_t rand_beat();
		in_beat_t b;
		b     = in_beat_t'($urandom);
		b.pad = 1'b0;
		if ($urandom_range(0, 1) == 1)
			b.clock_source = SRC_PLL;
		return b;
	endfunction

	task automatic add_row(in_beat_t b, bit known, logic [31:0] sys, logic [31:0] ahb,
		logic [31:0] apb1, logic [31:0] apb2);
		dir_beat.push_back(b);
		dir_known.push_back(known);
		dir_want.push_back({apb2, apb1, ahb, sys});
	endtask

	// Drive one query beat, opening a new burst after a random gap when due
	task automatic send_query(in_beat_t b, out_beat_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = no_gaps ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tdata  <= b;
		cur_want <= want;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Let every outstanding result come back, then let the pipe settle
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (freq_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register, then hold the channel idle before returning
	task automatic cfg_write(logic [1:0] idx, logic [25:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CRYSTAL:  xtal_hz = data;
			REG_INTERNAL: irc_hz  = data;
			default:      ;
		endcase
		@(posedge clk);
	endtask

	// Receiver: always ready, random stalls, a short periodic stall, long square-wave stalls
	always @(posedge clk) begin
		cyc <= cyc + 12'd1;
		case (cyc[9:8])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 2) != 0);
			2'd2: m_tready <= (cyc[2:0] != 3'd5);
			default: m_tready <= cyc[4];
		endcase
	end

	// Record accepted queries, check result beats, watch for a hang
	always @(posedge clk) begin : freq_monitor
		logic [127:0] want;
		logic [127:0] got;
		if (s_tvalid && s_tready)
			freq_q.push_back(cur_want);
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (freq_q.size() == 0) begin
				$error("result beat with no query outstanding: %h", got);
				fail_cnt++;
			end else begin
				want = freq_q.pop_front();
				for (int k = 0; k < 4; k++) begin
					if (got[32*k +: 32] !== want[32*k +: 32]) begin
						$error("%s: expected %0d, got %0d", field_name[k],
							want[32*k +: 32], got[32*k +: 32]);
						fail_cnt++;
					end
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= WATCHDOG_LIMIT) begin
			$display("clock_tree_frequency_calc regression: fail");
			$finish;
		end
	end

	// Stimulus
	initial begin
		out_beat_t want;

		// Directed rows; plain frequencies typed in, the rest predicted
		add_row(mk_beat(SRC_INTERNAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			8000000, 8000000, 8000000, 8000000);
		add_row(mk_beat(SRC_CRYSTAL, 0, 0, 0, 0, 0, 0, 0, 15, 7, 4), 1,
			8000000, 15625, 976, 7812);
		add_row(mk_beat(SRC_INTERNAL_ALT, 15, 1, 15, 1, 15, 15, 1, 15, 7, 7), 1,
			8000000, 15625, 976, 976);
		add_row(mk_beat(SRC_PLL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			72000000, 72000000, 72000000, 72000000);
		add_row(mk_beat(SRC_PLL, 13, 0, 0, 0, 0, 0, 1, 0, 0, 0), 1,
			52000000, 52000000, 52000000, 52000000);
		add_row(mk_beat(SRC_PLL, 7, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
			72000000, 72000000, 72000000, 72000000);
		add_row(mk_beat(SRC_PLL, 7, 1, 4, 1, 6, 4, 0, 0, 0, 0), 1,
			23040000, 23040000, 23040000, 23040000);
		add_row(mk_beat(SRC_CRYSTAL, 0, 0, 0, 0, 0, 0, 0, 12, 5, 6), 1,
			8000000, 125000, 31250, 15625);
		add_row(mk_beat(SRC_PLL, 15, 1, 15, 1, 0, 15, 1, 8, 4, 7), 0, 0, 0, 0, 0);
		add_row(mk_beat(SRC_PLL, 1, 1, 1, 1, 1, 0, 0, 9, 6, 5), 0, 0, 0, 0, 0);
		add_row(mk_beat(SRC_PLL, 14, 1, 0, 1, 15, 0, 0, 10, 3, 2), 0, 0, 0, 0, 0);
		add_row(mk_beat(SRC_PLL, 13, 1, 2, 0, 9, 3, 1, 11, 6, 1), 0, 0, 0, 0, 0);
		add_row(mk_beat(SRC_PLL, 2, 0, 15, 1, 15, 15, 0, 13, 7, 0), 0, 0, 0, 0, 0);
		add_row(mk_beat(SRC_CRYSTAL, 5, 1, 3, 1, 9, 7, 1, 13, 1, 3), 0, 0, 0, 0, 0);
		add_row(mk_beat(SRC_INTERNAL, 11, 1, 5, 1, 12, 8, 0, 14, 0, 7), 0, 0, 0, 0, 0);

		// Hold reset, then release
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass on the reset oscillator values
		for (int i = 0; i < dir_beat.size(); i++) begin
			want = dir_known[i] ? dir_want[i] : freq_predict(dir_beat[i]);
			send_query(dir_beat[i], want);
		end

		// Random phases, one oscillator setting each
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			no_gaps = (ph == 2 || ph == 7);
			if (ph == 6) begin
				cfg_write(REG_CRYSTAL, 26'($urandom_range(1, 50000000)));
				cfg_write(REG_INTERNAL, 26'($urandom_range(1, 50000000)));
			end else if (ph != 0) begin
				cfg_write(REG_CRYSTAL, XTAL_SET[ph]);
				cfg_write(REG_INTERNAL, IRC_SET[ph]);
			end
			// Undecoded indexes must leave both oscillators alone
			if (ph == 5) begin
				cfg_write(REG_SPARE_A, 26'($urandom));
				cfg_write(REG_SPARE_B, 26'($urandom));
			end
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				in_beat_t b;
				b = rand_beat();
				send_query(b, freq_predict(b));
			end
		end

		drain();
		if (fail_cnt == 0)
			$display("clock_tree_frequency_calc regression: pass");
		else
			$display("clock_tree_frequency_calc regression: fail");
		$finish;
	end

endmodule
